// File: design/ssh_auth_failure_parser_macros.svh
// Assertion helpers shared by the parser modules.
`ifndef SSH_AUTH_FAILURE_PARSER_MACROS_SVH
`define SSH_AUTH_FAILURE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SSHAFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sshafp assertion failed");

// Next-cycle implication, disabled while in reset.
`define SSHAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sshafp assertion failed");

`endif

// File: design/sshafp_pkg.sv
package sshafp_pkg;

  localparam int INDEX_BITS = 32;   // byte counter width, 8..32
  localparam int LEN_W      = 32;   // name-list length field
  localparam int CMP_W      = 34;   // headroom for index/length compares without wrap
  localparam int HDR_BYTES  = 5;    // type byte + 4 length bytes

  localparam int NAMES    = 3;
  localparam int NAME_MAX = 9;
  localparam int TOK_W    = 4;

  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Names packed first character in the top byte; password padded at the end.
  localparam logic [NAMES-1:0][8*NAME_MAX-1:0] NAME_TEXT =
    {"hostbased", {"password", 8'h00}, "publickey"};
  localparam logic [NAMES-1:0][TOK_W-1:0] NAME_LEN = {4'd9, 4'd8, 4'd9};

  localparam int QDEPTH = 2;   // power of two
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_PARTIAL = 2'd0;
  localparam outcome_t OUT_FAILURE = 2'd1;
  localparam outcome_t OUT_ERROR   = 2'd2;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_LIST,
    KIND_LIST_END,
    KIND_PARTIAL
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       err;     // framing bad for a final byte
    logic       len_nz;  // name list not empty
  } item_t;

  function automatic logic [7:0] name_char(input logic [1:0] k, input logic [TOK_W-1:0] pos);
    logic [TOK_W-1:0] p_rev;
    p_rev = TOK_W'(NAME_MAX - 1) - pos;
    name_char = (pos < TOK_W'(NAME_MAX)) ? NAME_TEXT[k][{p_rev, 3'b000} +: 8] : 8'h00;
  endfunction

  // Names whose full text has been matched by the current token.
  function automatic logic [NAMES-1:0] token_hits(input logic [NAMES-1:0] alive,
                                                  input logic [TOK_W-1:0] pos);
    logic [NAMES-1:0] h;
    h = '0;
    for (int k = 0; k < NAMES; k++) begin
      h[k] = alive[k] && (pos == NAME_LEN[k]);
    end
    token_hits = h;
  endfunction

  function automatic logic [NAMES-1:0] feed_char(input logic [NAMES-1:0] alive,
                                                 input logic [TOK_W-1:0] pos,
                                                 input logic [7:0] c);
    logic [NAMES-1:0] a;
    a = '0;
    for (int k = 0; k < NAMES; k++) begin
      a[k] = alive[k] && (pos < NAME_LEN[k]) && (name_char(2'(k), pos) == c);
    end
    feed_char = a;
  endfunction

endpackage

// File: design/sshafp_front.sv
module sshafp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_payload_byte,
  input  logic                 in_last_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output sshafp_pkg::item_t    q_item
);

  logic [sshafp_pkg::INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [sshafp_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [sshafp_pkg::CMP_W-1:0]      lim_r, lim_nxt;   // list length + 5

  logic                         sat;
  logic [sshafp_pkg::CMP_W-1:0] idx_c, idx_inc;
  logic                         len_zone, list_zone;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign sat       = (idx_r == {sshafp_pkg::INDEX_BITS{1'b1}});
  assign idx_c     = sshafp_pkg::CMP_W'(idx_r);
  assign idx_inc   = idx_c + sshafp_pkg::CMP_W'(1);
  assign len_zone  = (idx_r >= sshafp_pkg::INDEX_BITS'(1)) &&
                     (idx_r <= sshafp_pkg::INDEX_BITS'(4));
  assign list_zone = (idx_r >= sshafp_pkg::INDEX_BITS'(sshafp_pkg::HDR_BYTES)) && !sat;

  always_comb begin
    q_item.data   = in_payload_byte;
    q_item.last   = in_last_byte;
    q_item.kind   = sshafp_pkg::KIND_SKIP;
    if (list_zone) begin
      if (idx_c < lim_r) begin
        q_item.kind = (idx_inc == lim_r) ? sshafp_pkg::KIND_LIST_END : sshafp_pkg::KIND_LIST;
      end else if (idx_c == lim_r) begin
        q_item.kind = sshafp_pkg::KIND_PARTIAL;
      end
    end
    // total = idx+1 must equal len+6, i.e. idx == len+5
    q_item.err    = sat || (idx_r < sshafp_pkg::INDEX_BITS'(sshafp_pkg::HDR_BYTES)) ||
                    (idx_c != lim_r);
    q_item.len_nz = (len_r != '0);
  end

  always_comb begin
    idx_nxt = sat ? idx_r : idx_r + sshafp_pkg::INDEX_BITS'(1);
    len_nxt = len_zone ? {len_r[sshafp_pkg::LEN_W-9:0], in_payload_byte} : len_r;
    lim_nxt = sshafp_pkg::CMP_W'(len_nxt) + sshafp_pkg::CMP_W'(sshafp_pkg::HDR_BYTES);
    if (in_last_byte) begin
      idx_nxt = '0;
      len_nxt = '0;
      lim_nxt = sshafp_pkg::CMP_W'(sshafp_pkg::HDR_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      len_r <= '0;
      lim_r <= sshafp_pkg::CMP_W'(sshafp_pkg::HDR_BYTES);
    end else if (q_push) begin
      idx_r <= idx_nxt;
      len_r <= len_nxt;
      lim_r <= lim_nxt;
    end
  end

endmodule

// File: design/sshafp_queue.sv
`include "ssh_auth_failure_parser_macros.svh"

module sshafp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sshafp_pkg::item_t  push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output sshafp_pkg::item_t  head_item
);

  sshafp_pkg::item_t                 slot_r [sshafp_pkg::QDEPTH];
  logic [sshafp_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [sshafp_pkg::QCNT_W-1:0]     count_r;

  assign full       = (count_r == sshafp_pkg::QCNT_W'(sshafp_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + sshafp_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + sshafp_pkg::QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + sshafp_pkg::QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - sshafp_pkg::QCNT_W'(1);
    end
  end

  `SSHAFP_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, count_r <= sshafp_pkg::QCNT_W'(sshafp_pkg::QDEPTH))
  `SSHAFP_ASSERT_IMPL(a_ptr_gap, clk, rst_n, 1'b1, (wr_ptr_r - rd_ptr_r) == count_r[sshafp_pkg::QPTR_W-1:0])
  `SSHAFP_ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop, count_r == $past(count_r) + sshafp_pkg::QCNT_W'(1))

endmodule

// File: design/sshafp_back.sv
`include "ssh_auth_failure_parser_macros.svh"

module sshafp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sshafp_pkg::item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_method_mask,
  output logic                out_mask_valid,
  output logic [1:0]          out_outcome
);

  logic [sshafp_pkg::TOK_W-1:0] tok_pos_r, tok_pos_nxt;
  logic [sshafp_pkg::NAMES-1:0] alive_r, alive_nxt;
  logic [sshafp_pkg::NAMES-1:0] found_r, found_nxt;
  logic                         ended_r, ended_nxt;
  logic                         partial_r, partial_nxt;

  logic                         out_valid_r;
  logic [2:0]                   out_mask_r, res_mask;
  logic                         out_mv_r, res_mv;
  sshafp_pkg::outcome_t         out_outcome_r, res_outcome;

  logic out_free;
  logic is_list;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = q_valid && (!q_item.last || out_free);
  assign is_list  = (q_item.kind == sshafp_pkg::KIND_LIST) ||
                    (q_item.kind == sshafp_pkg::KIND_LIST_END);

  // Token matcher and partial-success capture.
  always_comb begin
    tok_pos_nxt = tok_pos_r;
    alive_nxt   = alive_r;
    found_nxt   = found_r;
    ended_nxt   = ended_r;
    partial_nxt = partial_r;
    if (is_list && !ended_r) begin
      if (q_item.data == sshafp_pkg::CHAR_NUL) begin
        found_nxt   = found_nxt | sshafp_pkg::token_hits(alive_nxt, tok_pos_nxt);
        ended_nxt   = 1'b1;
        alive_nxt   = '0;
        tok_pos_nxt = '0;
      end else if (q_item.data == sshafp_pkg::CHAR_COMMA) begin
        found_nxt   = found_nxt | sshafp_pkg::token_hits(alive_nxt, tok_pos_nxt);
        alive_nxt   = '1;
        tok_pos_nxt = '0;
      end else begin
        alive_nxt   = sshafp_pkg::feed_char(alive_r, tok_pos_r, q_item.data);
        tok_pos_nxt = (tok_pos_r == '1) ? tok_pos_r : tok_pos_r + sshafp_pkg::TOK_W'(1);
      end
      // list end closes the open token
      if (!ended_nxt && q_item.kind == sshafp_pkg::KIND_LIST_END) begin
        found_nxt   = found_nxt | sshafp_pkg::token_hits(alive_nxt, tok_pos_nxt);
        alive_nxt   = '1;
        tok_pos_nxt = '0;
      end
    end
    if (q_item.kind == sshafp_pkg::KIND_PARTIAL) begin
      partial_nxt = (q_item.data != 8'h00);
    end
  end

  always_comb begin
    res_mask    = '0;
    res_mv      = 1'b0;
    res_outcome = sshafp_pkg::OUT_ERROR;
    if (!q_item.err) begin
      if (partial_nxt) begin
        if (q_item.len_nz) begin
          res_outcome = sshafp_pkg::OUT_PARTIAL;
          res_mask    = found_nxt;
          res_mv      = 1'b1;
        end
      end else begin
        res_outcome = sshafp_pkg::OUT_FAILURE;
        if (q_item.len_nz) begin
          res_mask = found_nxt;
          res_mv   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_pos_r   <= '0;
      alive_r     <= '1;
      found_r     <= '0;
      ended_r     <= 1'b0;
      partial_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_item.last) begin
          tok_pos_r <= '0;
          alive_r   <= '1;
          found_r   <= '0;
          ended_r   <= 1'b0;
          partial_r <= 1'b0;
        end else begin
          tok_pos_r <= tok_pos_nxt;
          alive_r   <= alive_nxt;
          found_r   <= found_nxt;
          ended_r   <= ended_nxt;
          partial_r <= partial_nxt;
        end
      end
      if (q_pop && q_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      out_mask_r    <= res_mask;
      out_mv_r      <= res_mv;
      out_outcome_r <= res_outcome;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_method_mask = out_mask_r;
  assign out_mask_valid  = out_mv_r;
  assign out_outcome     = out_outcome_r;

  `SSHAFP_ASSERT_NEXT(a_clear_after_last, clk, rst_n, q_pop && q_item.last, !ended_r && (alive_r == '1) && (found_r == '0))
  `SSHAFP_ASSERT_IMPL(a_ended_dead, clk, rst_n, ended_r, alive_r == '0)
  `SSHAFP_ASSERT_IMPL(a_err_no_mask, clk, rst_n, out_valid_r && (out_outcome_r == sshafp_pkg::OUT_ERROR), (out_mask_r == '0) && !out_mv_r)

endmodule

// File: design/ssh_auth_failure_parser.sv
// Channel   Direction  Payload                                       Handshake
// in_       input      payload_byte[7:0], last_byte                  in_valid / in_ready
// out_      output     method_mask[2:0], mask_valid, outcome[1:0]    out_valid / out_ready
//
// One byte per cycle sustained unless out_ stalls. A byte is classified by the front
// counter and enters a two-entry queue; the matcher drains one entry per cycle, save a
// last byte held for out_ready. A result shows on out_ the cycle after it leaves the queue.
// Reset (rst_n low, synchronous) empties the queue and clears parser state.
// Output stalls back up through the queue; in_ready depends only on queue fill.
module ssh_auth_failure_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_method_mask,
  output logic       out_mask_valid,
  output logic [1:0] out_outcome
);

  // front -> queue
  logic              q_push, q_full;
  sshafp_pkg::item_t q_in_item;
  // queue -> back
  logic              q_pop, q_valid;
  sshafp_pkg::item_t q_head;

  // Front: byte counter, list length, field classification, framing check.
  sshafp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_payload_byte(in_payload_byte),
    .in_last_byte   (in_last_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in_item)
  );

  // Decouples the two halves so an output stall does not hit in_ready directly.
  sshafp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (q_head)
  );

  // Back: name matching, partial-success byte, result register.
  sshafp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_method_mask(out_method_mask),
    .out_mask_valid (out_mask_valid),
    .out_outcome    (out_outcome)
  );

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BYTES = 1600;
  localparam int DRAIN_CYCLES = 20;      // two-entry queue plus output stage

  // End of the byte counter range: the counter sticks here.
  localparam logic [63:0] POS_MAX = (64'd1 << sshafp_pkg::INDEX_BITS) - 64'd1;

  typedef logic [7:0] byte_q_t[$];

  // One result as the block presents it.
  typedef struct packed {
    logic [2:0]           mask;
    logic                 valid;
    sshafp_pkg::outcome_t outcome;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_payload_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_method_mask;
  logic       out_mask_valid;
  logic [1:0] out_outcome;

  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned ready_hold  = 0;
  bit          no_idle     = 1'b0;  // set during stretches with no gaps at all

  verdict_t expected_verdicts[$];

  // Method names in mask bit order.
  string method_name[3] = '{"publickey", "password", "hostbased"};

  // Parser model state.
  logic [63:0] byte_pos;
  logic [31:0] list_len;
  logic [3:0]  tok_len;
  logic [2:0]  live_names;
  logic [2:0]  seen_methods;
  logic        list_stopped;
  logic        partial_seen;

  ssh_auth_failure_parser DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_method_mask (out_method_mask),
    .out_mask_valid  (out_mask_valid),
    .out_outcome     (out_outcome)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    byte_pos     = '0;
    list_len     = '0;
    tok_len      = '0;
    live_names   = '1;
    seen_methods = '0;
    list_stopped = 1'b0;
    partial_seen = 1'b0;
  endfunction

  // End of a name: any candidate still alive at its exact length is a hit.
  function automatic void close_name();
    for (int k = 0; k < 3; k++) begin
      if (live_names[k] && tok_len == method_name[k].len()) seen_methods[k] = 1'b1;
    end
    tok_len    = '0;
    live_names = '1;
  endfunction

  function automatic void parse_step(input logic [7:0] b, input logic lst);
    logic [63:0] idx;
    logic [63:0] pos;
    logic [63:0] total;
    logic [63:0] need;
    logic        sat;
    logic [2:0]  alive;
    verdict_t    v;
    idx = byte_pos;
    sat = (idx == POS_MAX);
    if (idx >= 1 && idx <= 4) begin
      // big-endian length field
      list_len = {list_len[23:0], b};
    end else if (idx >= 5 && !sat) begin
      pos = idx - 64'd5;
      if (pos < {32'd0, list_len}) begin
        if (!list_stopped) begin
          if (b == sshafp_pkg::CHAR_NUL) begin
            // a NUL ends the current name and freezes the mask
            close_name();
            list_stopped = 1'b1;
            live_names   = '0;
          end else if (b == sshafp_pkg::CHAR_COMMA) begin
            close_name();
          end else begin
            alive = '0;
            for (int k = 0; k < 3; k++) begin
              if (live_names[k] && tok_len < method_name[k].len() &&
                  method_name[k][tok_len] == b) alive[k] = 1'b1;
            end
            live_names = alive;
            if (tok_len != 4'hf) tok_len++;
          end
          if (!list_stopped && pos + 64'd1 == {32'd0, list_len}) close_name();
        end
      end else if (pos == {32'd0, list_len}) begin
        partial_seen = (b != 8'h00);
      end
    end
    if (!sat) byte_pos = idx + 64'd1;

    if (lst) begin
      total = idx + 64'd1;
      need  = {32'd0, list_len} + 64'd6;  // 64-bit sum, no wrap
      v.mask    = '0;
      v.valid   = 1'b0;
      v.outcome = sshafp_pkg::OUT_ERROR;
      if (sat || total < 64'd6 || total != need) begin
        v.outcome = sshafp_pkg::OUT_ERROR;
      end else if (partial_seen) begin
        // partial success with an empty list is malformed
        if (list_len != 0) begin
          v.outcome = sshafp_pkg::OUT_PARTIAL;
          v.mask    = seen_methods;
          v.valid   = 1'b1;
        end
      end else begin
        v.outcome = sshafp_pkg::OUT_FAILURE;
        if (list_len != 0) begin
          v.mask  = seen_methods;
          v.valid = 1'b1;
        end
      end
      expected_verdicts.push_back(v);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: outputs are checked first, then the accepted byte is modeled.
  // A verdict never leaves in the cycle its final byte is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result transfer with no verdict pending");
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_method_mask !== want.mask) begin
            $error("method_mask: expected %0d, got %0d", want.mask, out_method_mask);
            errors++;
          end
          if (out_mask_valid !== want.valid) begin
            $error("mask_valid: expected %0d, got %0d", want.valid, out_mask_valid);
            errors++;
          end
          if (out_outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_outcome);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) parse_step(in_payload_byte, in_last_byte);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready  <= 1'b1;
      ready_hold = idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One byte transfer. Valid drops only on the falling edge that opens a gap,
  // so it is never lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_last_byte    <= lst;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_payload(input byte_q_t m);
    for (int i = 0; i < m.size(); i++) send_byte(m[i], i == m.size() - 1);
  endtask

  function automatic byte_q_t with_text(input byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Type byte, length field, list, partial-success byte.
  function automatic byte_q_t frame(input byte_q_t list, input logic [7:0] partial,
                                    input logic [7:0] msg_type = 8'd51);
    byte_q_t     m;
    logic [31:0] n;
    n = list.size();
    m.push_back(msg_type);
    for (int i = 3; i >= 0; i--) m.push_back(n[8*i +: 8]);
    m = {m, list};
    m.push_back(partial);
    return m;
  endfunction

  function automatic byte_q_t text_frame(input string s, input logic [7:0] partial);
    byte_q_t e;
    return frame(with_text(e, s), partial);
  endfunction

  // A random name: exact methods, near misses, empty, or random bytes
  // (sometimes longer than the name counter can hold).
  function automatic string pick_name();
    string s;
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1:    s = "publickey";
      2, 3:    s = "password";
      4, 5:    s = "hostbased";
      6:       s = "";
      7: begin
        s = method_name[$urandom_range(0, 2)];
        s = ($urandom_range(0, 1) != 0) ? s.substr(0, s.len() - 2) : {s, "x"};
      end
      default: begin
        s = "";
        n = $urandom_range(1, 20);
        repeat (n) s = {s, string'(8'($urandom_range(33, 126)))};
      end
    endcase
    return s;
  endfunction

  function automatic byte_q_t random_list();
    byte_q_t     l;
    int unsigned names;
    names = $urandom_range(0, 5);
    for (int i = 0; i < names; i++) begin
      if (i > 0) l.push_back(sshafp_pkg::CHAR_COMMA);
      l = with_text(l, pick_name());
      if ($urandom_range(0, 9) == 0) l.push_back(sshafp_pkg::CHAR_NUL);
    end
    return l;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every method, each alone and all together; partial success is set for the
  // full list and for hostbased alone. Runs with no gaps on either side.
  task automatic test_methods();
    no_idle = 1'b1;
    send_payload(text_frame("publickey,password,hostbased", 8'h01));
    send_payload(text_frame("password", 8'h00));
    send_payload(text_frame("hostbased", 8'hff));
    send_payload(text_frame("publickey", 8'h00));
    no_idle = 1'b0;
  endtask

  // Prefixes, extensions and case changes must not match.
  task automatic test_near_misses();
    send_payload(text_frame("publickeys,passwor,hostbase,PASSWORD", 8'h80));
    send_payload(text_frame("publickeypublickey", 8'h00));
  endtask

  // Adjacent, leading and trailing commas give empty names.
  task automatic test_empty_names();
    send_payload(text_frame(",,publickey,,", 8'h00));
    send_payload(text_frame("password,", 8'h01));
    send_payload(text_frame(",", 8'h00));
  endtask

  // NUL inside the list stops matching for the rest of the payload.
  task automatic test_zero_byte();
    byte_q_t l;
    l = with_text(l, "password");
    l.push_back(sshafp_pkg::CHAR_NUL);
    l = with_text(l, "publickey");
    send_payload(frame(l, 8'h01));
    l = {};
    l.push_back(sshafp_pkg::CHAR_NUL);
    l = with_text(l, "hostbased");
    send_payload(frame(l, 8'h00));
  endtask

  // Empty list: failure without a mask, error with partial success.
  task automatic test_empty_list();
    byte_q_t e;
    send_payload(frame(e, 8'h00));
    send_payload(frame(e, 8'h01));
  endtask

  // Payloads of one to five bytes.
  task automatic test_too_short();
    byte_q_t m;
    m = text_frame("password", 8'h00);
    for (int n = 1; n <= 5; n++) send_payload(m[0:n-1]);
  endtask

  // Declared length off by one either way, and a length near the top of the
  // field where a 32-bit sum would wrap.
  task automatic test_length_mismatch();
    byte_q_t m;
    m = text_frame("hostbased", 8'h00);
    m.push_back(8'h00);
    send_payload(m);
    m = text_frame("hostbased", 8'h00);
    void'(m.pop_back());
    send_payload(m);
    m = {8'h33, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00};
    send_payload(m);
    m = {8'h33, 8'hff, 8'hff, 8'hff, 8'hfa, 8'h70, 8'h01};
    send_payload(m);
  endtask

  // Mostly well-formed payloads with random lists; the rest are framing
  // faults and raw noise.
  task automatic test_random_traffic();
    byte_q_t     m;
    int unsigned start;
    int unsigned r;
    int unsigned n;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 5) == 0);
      m = frame(random_list(),
                ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                8'($urandom));
      r = $urandom_range(0, 99);
      if (r >= 70 && r < 88) begin
        case ($urandom_range(0, 3))
          0: begin
            n = $urandom_range(1, 3);
            while (n > 0 && m.size() > 1) begin
              void'(m.pop_back());
              n--;
            end
          end
          1: repeat ($urandom_range(1, 3)) m.push_back(8'($urandom));
          2: m[$urandom_range(1, 4)] = 8'($urandom);
          default: m = m[0:$urandom_range(0, 4)];
        endcase
      end else if (r >= 88) begin
        m = {};
        repeat ($urandom_range(1, 12)) m.push_back(8'($urandom));
      end
      send_payload(m);
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_payload_byte = 8'h00;
    in_last_byte    = 1'b0;
    clear_parser();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_methods();
    test_near_misses();
    test_empty_names();
    test_zero_byte();
    test_empty_list();
    test_too_short();
    test_length_mismatch();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
